// ===== design/grid_stencil_neighbor_enumerator_top_assert.svh =====
// ----------------------------------------------------------------------------
// Grid stencil neighbor enumerator assertion macros
// Concurrent assertion wrappers shared by the design files. Define ASSERT_OFF
// to compile them out.
// ----------------------------------------------------------------------------
`ifndef GRID_STENCIL_NEIGHBOR_ENUMERATOR_TOP_ASSERT_SVH
`define GRID_STENCIL_NEIGHBOR_ENUMERATOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define GSNE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GSNE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define GSNE_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define GSNE_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== design/gsne_pkg.sv =====
// ----------------------------------------------------------------------------
// Grid stencil neighbor enumerator package
// Field widths, operation and register codes, and the structs that pass
// between the enumerator modules.
// ----------------------------------------------------------------------------
package gsne_pkg;

   localparam int IDX_W       = 30;  // linear vertex index
   localparam int SLOT_W      = 5;   // stencil slot field
   localparam int ENTRY_IDX_W = 5;   // load slot field
   localparam int DELTA_W     = 4;   // one signed displacement
   localparam int ENTRY_W     = 3 * DELTA_W;
   localparam int FLAGS_W     = 6;
   localparam int DIM_CFG_W   = 11;
   localparam int CNT_CFG_W   = 6;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int REG_SEL_W   = 2;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_ENUM = 1'b1;

   localparam logic [REG_SEL_W-1:0] REG_DIM_X     = 2'd0;
   localparam logic [REG_SEL_W-1:0] REG_DIM_Y     = 2'd1;
   localparam logic [REG_SEL_W-1:0] REG_DIM_Z     = 2'd2;
   localparam logic [REG_SEL_W-1:0] REG_NBR_COUNT = 2'd3;

   // stencil table write from the request side
   typedef struct packed {
      logic                   en;
      logic [ENTRY_IDX_W-1:0] idx;
      logic [ENTRY_W-1:0]     data;   // dz, dy, dx from msb down
   } tbl_wr_type;

   // one response as registered at the output
   typedef struct packed {
      logic               valid;
      logic [SLOT_W-1:0]  slot;
      logic [IDX_W-1:0]   nb_idx;
      logic [FLAGS_W-1:0] flags;
      logic               none_inside;
      logic               last;
   } rsp_type;

endpackage

// ===== design/gsne_div.sv =====
// ----------------------------------------------------------------------------
// Grid stencil neighbor enumerator divider
// Restoring radix-2 divider, one quotient bit per cycle, for splitting a
// linear index into grid coordinates.
// ----------------------------------------------------------------------------
module gsne_div #(
   parameter int DW = 11
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [gsne_pkg::IDX_W-1:0] dividend,
   input  logic [DW-1:0]              divisor,
   output logic                       done,
   output logic [gsne_pkg::IDX_W-1:0] quotient,
   output logic [DW-1:0]              remainder
);
   import gsne_pkg::*;

   localparam int SW = $clog2(IDX_W);

   logic             busy_ff;
   logic             done_ff;
   logic [SW-1:0]    step_ff;
   logic [IDX_W-1:0] quo_ff;
   logic [DW-1:0]    rem_ff;
   logic [DW-1:0]    dvs_ff;
   logic [DW:0]      trial;
   logic             fits;

   assign trial = {rem_ff, quo_ff[IDX_W-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= busy_ff && !start && (step_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= SW'(IDX_W - 1);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == '0) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // shift in one dividend bit, subtract when it fits
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? DW'(trial - {1'b0, dvs_ff}) : DW'(trial);
         quo_ff <= {quo_ff[IDX_W-2:0], fits};
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== design/gsne_walk.sv =====
`include "grid_stencil_neighbor_enumerator_top_assert.svh"
// ----------------------------------------------------------------------------
// Grid stencil neighbor enumerator table walker
// Holds the stencil table memory, walks the active slots, checks bounds,
// forms neighbor indexes and registers the response stream.
// ----------------------------------------------------------------------------
module gsne_walk #(
   parameter int MAX_NEIGHBORS = 32,
   parameter int DIM_BITS      = 10
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  gsne_pkg::tbl_wr_type                      wr,
   input  logic                                      go,
   input  logic [$clog2(MAX_NEIGHBORS+1)-1:0]        cnt,
   input  logic [gsne_pkg::IDX_W-1:0]                origin,
   input  logic [DIM_BITS:0]                         x,
   input  logic [DIM_BITS:0]                         y,
   input  logic [gsne_pkg::IDX_W-1:0]                z,
   input  logic [DIM_BITS:0]                         nx,
   input  logic [DIM_BITS:0]                         ny,
   input  logic [DIM_BITS:0]                         nz,
   input  logic [gsne_pkg::IDX_W-1:0]                plane,
   output logic                                      done,
   output gsne_pkg::rsp_type                         rsp
);
   import gsne_pkg::*;

   localparam int AW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
   localparam int EXT_W = IDX_W - DELTA_W;

   function automatic logic in_rng(input logic [31:0] c, input logic [DELTA_W-1:0] d,
                                   input logic [31:0] n);
      logic signed [31:0] v;
      v = signed'(c) + signed'({{(32-DELTA_W){d[DELTA_W-1]}}, d});
      return (v >= 0) && (v < signed'(n));
   endfunction

   logic [ENTRY_W-1:0] tbl_mem [MAX_NEIGHBORS];

   // issue stage
   logic          issuing_ff;
   logic [AW-1:0] idx_ff;
   logic          idx_end;
   // memory output stage
   logic               s1_valid_ff;
   logic               s1_end_ff;
   logic [AW-1:0]      s1_slot_ff;
   logic [ENTRY_W-1:0] rd_data_ff;
   // bounds and products stage
   logic               s2_valid_ff;
   logic               s2_hit_ff;
   logic               s2_end_ff;
   logic [AW-1:0]      s2_slot_ff;
   logic [IDX_W-1:0]   prod_z_ff;
   logic [IDX_W-1:0]   prod_y_ff;
   logic [DELTA_W-1:0] s2_dx_ff;
   // pending hit and flush
   logic             pend_valid_ff;
   logic [AW-1:0]    pend_slot_ff;
   logic [IDX_W-1:0] pend_nb_ff;
   logic             flush_ff;
   rsp_type          rsp_ff;

   logic [DELTA_W-1:0] dx, dy, dz;
   logic               hit;
   logic [IDX_W-1:0]   nb_sum;
   logic [FLAGS_W-1:0] flags;
   rsp_type            rsp_in;

   assign idx_end = ((32'(idx_ff) + 32'd1) == 32'(cnt));

   always_ff @(posedge clock) begin
      if (wr.en && (32'(wr.idx) < 32'(MAX_NEIGHBORS))) begin
         tbl_mem[AW'(wr.idx)] <= wr.data;
      end
      rd_data_ff <= tbl_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff <= 1'b0;
         idx_ff     <= '0;
      end else if (go) begin
         issuing_ff <= (cnt != '0);
         idx_ff     <= '0;
      end else if (issuing_ff) begin
         idx_ff <= idx_ff + 1'b1;
         if (idx_end) begin
            issuing_ff <= 1'b0;
         end
      end
   end

   assign dx  = rd_data_ff[DELTA_W-1:0];
   assign dy  = rd_data_ff[2*DELTA_W-1:DELTA_W];
   assign dz  = rd_data_ff[3*DELTA_W-1:2*DELTA_W];
   assign hit = in_rng(32'(x), dx, 32'(nx)) && in_rng(32'(y), dy, 32'(ny))
                && in_rng(32'(z), dz, 32'(nz));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issuing_ff;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_end_ff  <= idx_end;
      s1_slot_ff <= idx_ff;
      s2_hit_ff  <= hit;
      s2_end_ff  <= s1_end_ff;
      s2_slot_ff <= s1_slot_ff;
      s2_dx_ff   <= dx;
      prod_z_ff  <= plane * {{EXT_W{dz[DELTA_W-1]}}, dz};
      prod_y_ff  <= IDX_W'(nx) * {{EXT_W{dy[DELTA_W-1]}}, dy};
   end

   assign nb_sum = origin + prod_z_ff + prod_y_ff + {{EXT_W{s2_dx_ff[DELTA_W-1]}}, s2_dx_ff};

   always_comb begin
      flags    = '0;
      flags[0] = (x == '0);
      flags[1] = (x != '0) && ((32'(x) + 32'd1) == 32'(nx));
      flags[2] = (y == '0);
      flags[3] = (y != '0) && ((32'(y) + 32'd1) == 32'(ny));
      flags[4] = (z == '0);
      flags[5] = (z != '0) && ((32'(z) + 32'd1) == 32'(nz));
   end

   // Hold each hit back by one so the final one can carry last.
   always_comb begin
      rsp_in             = rsp_ff;
      rsp_in.valid       = 1'b0;
      rsp_in.flags       = flags;
      rsp_in.none_inside = 1'b0;
      rsp_in.last        = 1'b0;
      if (flush_ff) begin
         rsp_in.valid = 1'b1;
         rsp_in.last  = 1'b1;
         if (pend_valid_ff) begin
            rsp_in.slot   = SLOT_W'(pend_slot_ff);
            rsp_in.nb_idx = pend_nb_ff;
         end else begin
            rsp_in.slot        = '0;
            rsp_in.nb_idx      = '0;
            rsp_in.none_inside = 1'b1;
         end
      end else if (s2_valid_ff && s2_hit_ff && pend_valid_ff) begin
         rsp_in.valid  = 1'b1;
         rsp_in.slot   = SLOT_W'(pend_slot_ff);
         rsp_in.nb_idx = pend_nb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         flush_ff      <= 1'b0;
         rsp_ff.valid  <= 1'b0;
      end else begin
         flush_ff <= (go && (cnt == '0)) || (s2_valid_ff && s2_end_ff);
         rsp_ff   <= rsp_in;
         if (go || flush_ff) begin
            pend_valid_ff <= 1'b0;
         end else if (s2_valid_ff && s2_hit_ff) begin
            pend_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff && s2_hit_ff) begin
         pend_slot_ff <= s2_slot_ff;
         pend_nb_ff   <= nb_sum;
      end
   end

   assign done = flush_ff;
   assign rsp  = rsp_ff;

   `GSNE_ASSERT_NXT(a_flush_emits_last, clock, reset, flush_ff, rsp_ff.valid && rsp_ff.last, "flush did not emit the final response")
   `GSNE_ASSERT_IMP(a_mid_keeps_pending, clock, reset, rsp_ff.valid && !rsp_ff.last, pend_valid_ff, "non-final response left no pending hit")
   `GSNE_ASSERT_IMP(a_go_when_quiet, clock, reset, go, !issuing_ff && !s1_valid_ff && !s2_valid_ff && !flush_ff, "walk started while a walk was in flight")

endmodule

// ===== design/grid_stencil_neighbor_enumerator_top.sv =====
`include "grid_stencil_neighbor_enumerator_top_assert.svh"
// ----------------------------------------------------------------------------
// Grid stencil neighbor enumerator
// Enumerates the in-bounds stencil neighbors of a vertex on a 3D grid.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A load request
// (req_op = 0) writes one stencil entry into the table in that same cycle and
// leaves busy low, so loads can follow back to back. An enumerate request
// (req_op = 1) raises busy, splits req_origin into x, y, z by two 30-step
// divisions on one shared bit-serial divider, then walks table slots
// 0 .. N-1 (N = neighbor_count, capped at MAX_NEIGHBORS) through the table
// memory, one slot per cycle. Responses come out on rsp_strobe, one cycle
// each, in slot order, and cannot be held off: the receiver must take every
// strobe. The final response of each enumeration has rsp_last set; when no
// neighbor lies inside the grid a single response with rsp_none_inside comes
// instead. An enumeration occupies the block for the two divisions, then for
// the table walk and a bounds and index pipeline. busy drops in the cycle
// the last response is on the ports. Configuration writes are legal only
// while idle.
// ----------------------------------------------------------------------------
module grid_stencil_neighbor_enumerator_top #(
   parameter int MAX_NEIGHBORS = 32,
   parameter int DIM_BITS      = 10
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel
   input  logic                                    start,
   output logic                                    busy,
   input  logic                                    req_op,
   input  logic [gsne_pkg::ENTRY_IDX_W-1:0]        req_entry_index,
   input  logic signed [gsne_pkg::DELTA_W-1:0]     req_delta_x,
   input  logic signed [gsne_pkg::DELTA_W-1:0]     req_delta_y,
   input  logic signed [gsne_pkg::DELTA_W-1:0]     req_delta_z,
   input  logic [gsne_pkg::IDX_W-1:0]              req_origin,
   // response channel
   output logic                                    rsp_strobe,
   output logic [gsne_pkg::SLOT_W-1:0]             rsp_slot,
   output logic [gsne_pkg::IDX_W-1:0]              rsp_neighbor_index,
   output logic [gsne_pkg::FLAGS_W-1:0]            rsp_boundary_flags,
   output logic                                    rsp_none_inside,
   output logic                                    rsp_last,
   // register port
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [gsne_pkg::CSR_ADDR_W-1:0]         paddr,
   input  logic [gsne_pkg::CSR_DATA_W-1:0]         pwdata,
   output logic [gsne_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                    pready
);
   import gsne_pkg::*;

   localparam int DW = DIM_BITS + 1;                  // effective extent width
   localparam int CW = $clog2(MAX_NEIGHBORS + 1);     // active slot count width

   // One-hot sequencer: idle, x division, y/z division, table walk.
   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_DIV_X = 4'b0010,
      S_DIV_Y = 4'b0100,
      S_WALK  = 4'b1000
   } state_type;

   // Clamp an extent to 1 .. 2^DIM_BITS.
   function automatic logic [DW-1:0] eff_dim(input logic [DIM_CFG_W-1:0] d);
      logic [31:0] d32;
      logic [31:0] cap;
      d32 = 32'(d);
      cap = 32'd1 << DIM_BITS;
      if (d32 == 32'd0) begin
         d32 = 32'd1;
      end else if (d32 > cap) begin
         d32 = cap;
      end
      return DW'(d32);
   endfunction

   // configuration registers
   logic [DIM_CFG_W-1:0] dim_x_ff, dim_y_ff, dim_z_ff;
   logic [CNT_CFG_W-1:0] nbr_cnt_ff;
   logic                 csr_wr;
   logic [REG_SEL_W-1:0] reg_sel;

   // sequencer and captured coordinates
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] origin_ff;
   logic [DW-1:0]    x_ff, y_ff;
   logic [IDX_W-1:0] z_ff;
   logic [IDX_W-1:0] plane_ff;
   logic             walk_go_ff;

   logic [DW-1:0]    nx, ny, nz;
   logic [2*DW-1:0]  plane_full;
   logic [CW-1:0]    cnt_sat;
   logic             accept;

   // divider hookup
   logic             div_start;
   logic [IDX_W-1:0] div_dividend;
   logic [DW-1:0]    div_divisor;
   logic             div_done;
   logic [IDX_W-1:0] div_quo;
   logic [DW-1:0]    div_rem;

   tbl_wr_type tbl_wr;
   logic       walk_done;
   rsp_type    rsp;

   // ---------------------------------------------------------------------
   // Register port: writes complete in the access phase, no wait states.
   // ---------------------------------------------------------------------
   assign pready  = 1'b1;
   assign reg_sel = paddr[CSR_ADDR_W-1:2];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_x_ff   <= DIM_CFG_W'(1);
         dim_y_ff   <= DIM_CFG_W'(1);
         dim_z_ff   <= DIM_CFG_W'(1);
         nbr_cnt_ff <= '0;
      end else if (csr_wr) begin
         unique case (reg_sel)
            REG_DIM_X:     dim_x_ff   <= pwdata[DIM_CFG_W-1:0];
            REG_DIM_Y:     dim_y_ff   <= pwdata[DIM_CFG_W-1:0];
            REG_DIM_Z:     dim_z_ff   <= pwdata[DIM_CFG_W-1:0];
            REG_NBR_COUNT: nbr_cnt_ff <= pwdata[CNT_CFG_W-1:0];
            default:       ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_DIM_X:     prdata = CSR_DATA_W'(dim_x_ff);
         REG_DIM_Y:     prdata = CSR_DATA_W'(dim_y_ff);
         REG_DIM_Z:     prdata = CSR_DATA_W'(dim_z_ff);
         REG_NBR_COUNT: prdata = CSR_DATA_W'(nbr_cnt_ff);
         default:       prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Effective extents, slot count and the xy plane size. The plane product
   // is registered; it settles long before a walk needs it.
   // ---------------------------------------------------------------------
   assign nx         = eff_dim(dim_x_ff);
   assign ny         = eff_dim(dim_y_ff);
   assign nz         = eff_dim(dim_z_ff);
   assign plane_full = nx * ny;
   assign cnt_sat    = (32'(nbr_cnt_ff) > 32'(MAX_NEIGHBORS)) ? CW'(MAX_NEIGHBORS)
                                                               : CW'(nbr_cnt_ff);

   always_ff @(posedge clock) begin
      plane_ff <= IDX_W'(plane_full);
   end

   // ---------------------------------------------------------------------
   // Request side: loads go straight to the table, enumerates start the
   // coordinate split.
   // ---------------------------------------------------------------------
   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   assign tbl_wr.en   = accept && (req_op == OP_LOAD);
   assign tbl_wr.idx  = req_entry_index;
   assign tbl_wr.data = {req_delta_z, req_delta_y, req_delta_x};

   // x = origin mod nx, q = origin / nx; then y = q mod ny, z = q / ny
   assign div_start    = (state_ff == S_IDLE) ? (accept && (req_op == OP_ENUM))
                                              : ((state_ff == S_DIV_X) && div_done);
   assign div_dividend = (state_ff == S_IDLE) ? req_origin : div_quo;
   assign div_divisor  = (state_ff == S_IDLE) ? nx : ny;

   gsne_div #(
      .DW (DW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_op == OP_ENUM)) begin
               state_in = S_DIV_X;
            end
         end
         S_DIV_X: begin
            if (div_done) begin
               state_in = S_DIV_Y;
            end
         end
         S_DIV_Y: begin
            if (div_done) begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (walk_done) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         walk_go_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         walk_go_ff <= (state_ff == S_DIV_Y) && div_done;
      end
   end

   // capture origin and coordinates as the divider delivers them
   always_ff @(posedge clock) begin
      if (accept) begin
         origin_ff <= req_origin;
      end
      if ((state_ff == S_DIV_X) && div_done) begin
         x_ff <= div_rem;
      end
      if ((state_ff == S_DIV_Y) && div_done) begin
         y_ff <= div_rem;
         z_ff <= div_quo;
      end
   end

   // ---------------------------------------------------------------------
   // Table walk and response stream
   // ---------------------------------------------------------------------
   gsne_walk #(
      .MAX_NEIGHBORS (MAX_NEIGHBORS),
      .DIM_BITS      (DIM_BITS)
   ) u_walk (
      .clock  (clock),
      .reset  (reset),
      .wr     (tbl_wr),
      .go     (walk_go_ff),
      .cnt    (cnt_sat),
      .origin (origin_ff),
      .x      (x_ff),
      .y      (y_ff),
      .z      (z_ff),
      .nx     (nx),
      .ny     (ny),
      .nz     (nz),
      .plane  (plane_ff),
      .done   (walk_done),
      .rsp    (rsp)
   );

   assign rsp_strobe         = rsp.valid;
   assign rsp_slot           = rsp.slot;
   assign rsp_neighbor_index = rsp.nb_idx;
   assign rsp_boundary_flags = rsp.flags;
   assign rsp_none_inside    = rsp.none_inside;
   assign rsp_last           = rsp.last;

   `GSNE_ASSERT_NXT(a_enum_goes_busy, clock, reset, start && !busy && (req_op == OP_ENUM), busy, "enumerate request did not raise busy")
   `GSNE_ASSERT_IMP(a_last_frees_block, clock, reset, rsp_strobe && rsp_last, !busy, "block still busy on final response")
   `GSNE_ASSERT_IMP(a_strobe_after_busy, clock, reset, rsp_strobe, $past(busy), "response without an enumeration in progress")

endmodule

// ===== tb/gsne_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Grid stencil neighbor enumerator checker
// Tracks register writes and stencil loads, predicts every enumeration and
// compares each response, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module gsne_checker #(
   parameter int MAX_NEIGHBORS = 32,
   parameter int DIM_BITS      = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic                                req_op,
   input  logic [gsne_pkg::ENTRY_IDX_W-1:0]    req_entry_index,
   input  logic signed [gsne_pkg::DELTA_W-1:0] req_delta_x,
   input  logic signed [gsne_pkg::DELTA_W-1:0] req_delta_y,
   input  logic signed [gsne_pkg::DELTA_W-1:0] req_delta_z,
   input  logic [gsne_pkg::IDX_W-1:0]          req_origin,
   input  logic                                rsp_strobe,
   input  logic [gsne_pkg::SLOT_W-1:0]         rsp_slot,
   input  logic [gsne_pkg::IDX_W-1:0]          rsp_neighbor_index,
   input  logic [gsne_pkg::FLAGS_W-1:0]        rsp_boundary_flags,
   input  logic                                rsp_none_inside,
   input  logic                                rsp_last,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [gsne_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [gsne_pkg::CSR_DATA_W-1:0]     pwdata,
   input  logic                                pready,
   input  logic                                drain_check,
   output int                                  outstanding,
   output int                                  mismatches
);

   typedef struct packed {
      logic [gsne_pkg::SLOT_W-1:0]  slot;
      logic [gsne_pkg::IDX_W-1:0]   nbr_index;
      logic [gsne_pkg::FLAGS_W-1:0] flags;
      logic                         none_inside;
      logic                         last;
   } nbr_result_type;

   nbr_result_type                    nbr_expected_q[$];
   logic [gsne_pkg::ENTRY_W-1:0]      stencil_tbl[MAX_NEIGHBORS];
   logic [gsne_pkg::DIM_CFG_W-1:0]    dim_x_q;
   logic [gsne_pkg::DIM_CFG_W-1:0]    dim_y_q;
   logic [gsne_pkg::DIM_CFG_W-1:0]    dim_z_q;
   logic [gsne_pkg::CNT_CFG_W-1:0]    count_q;
   nbr_result_type                    want;

   task automatic report_mismatch(input string what, input longint got, input longint exp_val);
      mismatches++;
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, exp_val);
   endtask

   // zero counts as one, oversize clamps to the widest grid
   function automatic longint extent(input logic [gsne_pkg::DIM_CFG_W-1:0] d);
      if (d == 0)
         return 1;
      if (d > (1 << DIM_BITS))
         return longint'(1) << DIM_BITS;
      return longint'(d);
   endfunction

   task automatic predict_enumeration(input logic [gsne_pkg::IDX_W-1:0] origin);
      longint                       nx, ny, nz, org, x, y, z, dx, dy, dz, nbr;
      int                           walk_len;
      logic [gsne_pkg::ENTRY_W-1:0] e;
      logic [gsne_pkg::FLAGS_W-1:0] flags;
      nbr_result_type               hit;
      nbr_result_type               hits[$];
      nx  = extent(dim_x_q);
      ny  = extent(dim_y_q);
      nz  = extent(dim_z_q);
      org = longint'(origin);
      x   = org % nx;
      y   = (org / nx) % ny;
      z   = org / (nx * ny);
      // low wins over high on a one-wide axis
      flags = '0;
      if (x == 0) flags[0] = 1'b1; else if (x == nx - 1) flags[1] = 1'b1;
      if (y == 0) flags[2] = 1'b1; else if (y == ny - 1) flags[3] = 1'b1;
      if (z == 0) flags[4] = 1'b1; else if (z == nz - 1) flags[5] = 1'b1;
      walk_len = (count_q > MAX_NEIGHBORS) ? MAX_NEIGHBORS : int'(count_q);
      for (int i = 0; i < walk_len; i++) begin
         e  = stencil_tbl[i];
         dx = $signed(e[3:0]);
         dy = $signed(e[7:4]);
         dz = $signed(e[11:8]);
         if (x + dx < 0 || x + dx >= nx || y + dy < 0 || y + dy >= ny ||
             z + dz < 0 || z + dz >= nz)
            continue;
         nbr             = org + dz * nx * ny + dy * nx + dx;
         hit.slot        = gsne_pkg::SLOT_W'(i);
         hit.nbr_index   = nbr[gsne_pkg::IDX_W-1:0];
         hit.flags       = flags;
         hit.none_inside = 1'b0;
         hit.last        = 1'b0;
         hits.push_back(hit);
      end
      if (hits.size() == 0) begin
         hit.slot        = '0;
         hit.nbr_index   = '0;
         hit.flags       = flags;
         hit.none_inside = 1'b1;
         hit.last        = 1'b1;
         hits.push_back(hit);
      end else begin
         hits[hits.size() - 1].last = 1'b1;
      end
      foreach (hits[k])
         nbr_expected_q.push_back(hits[k]);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         nbr_expected_q.delete();
         foreach (stencil_tbl[i])
            stencil_tbl[i] = '0;
         dim_x_q    = 1;
         dim_y_q    = 1;
         dim_z_q    = 1;
         count_q    = 0;
         mismatches = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[gsne_pkg::REG_SEL_W+1:2])
               gsne_pkg::REG_DIM_X:     dim_x_q = pwdata[gsne_pkg::DIM_CFG_W-1:0];
               gsne_pkg::REG_DIM_Y:     dim_y_q = pwdata[gsne_pkg::DIM_CFG_W-1:0];
               gsne_pkg::REG_DIM_Z:     dim_z_q = pwdata[gsne_pkg::DIM_CFG_W-1:0];
               gsne_pkg::REG_NBR_COUNT: count_q = pwdata[gsne_pkg::CNT_CFG_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (req_op == gsne_pkg::OP_LOAD) begin
               if (req_entry_index < MAX_NEIGHBORS)
                  stencil_tbl[req_entry_index] = {req_delta_z, req_delta_y, req_delta_x};
            end else begin
               predict_enumeration(req_origin);
            end
         end
         if (rsp_strobe) begin
            if (nbr_expected_q.size() == 0) begin
               report_mismatch("response with nothing pending, slot", rsp_slot, -1);
            end else begin
               want = nbr_expected_q.pop_front();
               if (rsp_slot != want.slot)
                  report_mismatch("slot", rsp_slot, want.slot);
               if (rsp_neighbor_index != want.nbr_index)
                  report_mismatch("neighbor_index", rsp_neighbor_index, want.nbr_index);
               if (rsp_boundary_flags != want.flags)
                  report_mismatch("boundary_flags", rsp_boundary_flags, want.flags);
               if (rsp_none_inside != want.none_inside)
                  report_mismatch("none_inside", rsp_none_inside, want.none_inside);
               if (rsp_last != want.last)
                  report_mismatch("last", rsp_last, want.last);
            end
         end
         if (drain_check && nbr_expected_q.size() != 0) begin
            report_mismatch("responses never delivered", 0, nbr_expected_q.size());
            nbr_expected_q.delete();
         end
      end
      outstanding <= nbr_expected_q.size();
   end

endmodule

// ===== tb/tb_grid_stencil_neighbor_enumerator_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Grid stencil neighbor enumerator testbench
// Loads stencil tables and sweeps grid shapes and neighbor counts, sending
// directed corner and overflow cases first and then random requests under
// several sender idle rates; the checker beside the block judges responses.
// ----------------------------------------------------------------------------
module tb_grid_stencil_neighbor_enumerator_top;

   localparam int MAX_NEIGHBORS = 32;
   localparam int DIM_BITS      = 10;
   localparam int IDX_LIMIT     = 1 << gsne_pkg::IDX_W;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 28;

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   logic                                req_op;
   logic [gsne_pkg::ENTRY_IDX_W-1:0]    req_entry_index;
   logic signed [gsne_pkg::DELTA_W-1:0] req_delta_x;
   logic signed [gsne_pkg::DELTA_W-1:0] req_delta_y;
   logic signed [gsne_pkg::DELTA_W-1:0] req_delta_z;
   logic [gsne_pkg::IDX_W-1:0]          req_origin;
   logic                                rsp_strobe;
   logic [gsne_pkg::SLOT_W-1:0]         rsp_slot;
   logic [gsne_pkg::IDX_W-1:0]          rsp_neighbor_index;
   logic [gsne_pkg::FLAGS_W-1:0]        rsp_boundary_flags;
   logic                                rsp_none_inside;
   logic                                rsp_last;
   logic                                psel;
   logic                                penable;
   logic                                pwrite;
   logic [gsne_pkg::CSR_ADDR_W-1:0]     paddr;
   logic [gsne_pkg::CSR_DATA_W-1:0]     pwdata;
   logic [gsne_pkg::CSR_DATA_W-1:0]     prdata;
   logic                                pready;
   logic                                drain_check;
   int                                  outstanding;
   int                                  mismatches;

   // percent chance of idling before each request; changes per phase
   int idle_pct;
   // raw extents as last programmed, used only to aim origins at the grid
   int dim_x_set, dim_y_set, dim_z_set;
   int phase_idle[PHASES] = '{0, 80, 0, 16, 80, 0, 16, 0};

   grid_stencil_neighbor_enumerator_top #(
      .MAX_NEIGHBORS(MAX_NEIGHBORS),
      .DIM_BITS     (DIM_BITS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_entry_index   (req_entry_index),
      .req_delta_x       (req_delta_x),
      .req_delta_y       (req_delta_y),
      .req_delta_z       (req_delta_z),
      .req_origin        (req_origin),
      .rsp_strobe        (rsp_strobe),
      .rsp_slot          (rsp_slot),
      .rsp_neighbor_index(rsp_neighbor_index),
      .rsp_boundary_flags(rsp_boundary_flags),
      .rsp_none_inside   (rsp_none_inside),
      .rsp_last          (rsp_last),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   gsne_checker #(
      .MAX_NEIGHBORS(MAX_NEIGHBORS),
      .DIM_BITS     (DIM_BITS)
   ) chk (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_entry_index   (req_entry_index),
      .req_delta_x       (req_delta_x),
      .req_delta_y       (req_delta_y),
      .req_delta_z       (req_delta_z),
      .req_origin        (req_origin),
      .rsp_strobe        (rsp_strobe),
      .rsp_slot          (rsp_slot),
      .rsp_neighbor_index(rsp_neighbor_index),
      .rsp_boundary_flags(rsp_boundary_flags),
      .rsp_none_inside   (rsp_none_inside),
      .rsp_last          (rsp_last),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .pready            (pready),
      .drain_check       (drain_check),
      .outstanding       (outstanding),
      .mismatches        (mismatches)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Write one register: setup cycle, then access cycle until pready, then
   // return the bus to idle.
   // Now and then set junk above the register width; the block must drop it.
   task automatic program_reg(input logic [gsne_pkg::REG_SEL_W-1:0] sel,
                              input int unsigned value);
      int w;
      w = (sel == gsne_pkg::REG_NBR_COUNT) ? gsne_pkg::CNT_CFG_W : gsne_pkg::DIM_CFG_W;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {sel, 2'b00};
      pwdata  <= value | (($urandom_range(0, 4) == 0) ? ($urandom << w) : 32'd0);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic program_grid(input int nx, input int ny, input int nz);
      dim_x_set = nx;
      dim_y_set = ny;
      dim_z_set = nz;
      program_reg(gsne_pkg::REG_DIM_X, nx);
      program_reg(gsne_pkg::REG_DIM_Y, ny);
      program_reg(gsne_pkg::REG_DIM_Z, nz);
   endtask

   // Present one request and hold it until the block takes it. start stays
   // high afterwards so back-to-back requests need no extra assignment.
   task automatic send(input logic op, input logic [gsne_pkg::ENTRY_IDX_W-1:0] slot_sel,
                       input logic [gsne_pkg::DELTA_W-1:0] ddx,
                       input logic [gsne_pkg::DELTA_W-1:0] ddy,
                       input logic [gsne_pkg::DELTA_W-1:0] ddz,
                       input logic [gsne_pkg::IDX_W-1:0] org);
      if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
         start <= 1'b0;
         do @(negedge clock); while ($urandom_range(1, 100) <= idle_pct);
      end
      start           <= 1'b1;
      req_op          <= op;
      req_entry_index <= slot_sel;
      req_delta_x     <= ddx;
      req_delta_y     <= ddy;
      req_delta_z     <= ddz;
      req_origin      <= org;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Load requests carry a random origin; it is a don't-care for them.
   task automatic load_slot(input int slot_sel, input logic [gsne_pkg::DELTA_W-1:0] ddx,
                            input logic [gsne_pkg::DELTA_W-1:0] ddy,
                            input logic [gsne_pkg::DELTA_W-1:0] ddz);
      send(gsne_pkg::OP_LOAD, gsne_pkg::ENTRY_IDX_W'(slot_sel), ddx, ddy, ddz,
           gsne_pkg::IDX_W'($urandom));
   endtask

   // Enumerate requests carry random slot and delta bits, also ignored.
   task automatic enumerate(input longint org);
      send(gsne_pkg::OP_ENUM, gsne_pkg::ENTRY_IDX_W'($urandom), gsne_pkg::DELTA_W'($urandom),
           gsne_pkg::DELTA_W'($urandom), gsne_pkg::DELTA_W'($urandom),
           gsne_pkg::IDX_W'(org));
   endtask

   // Drop start and hold off until every pending response is out, then
   // linger a few idle cycles.
   task automatic settle(input int linger);
      int waited;
      waited = 0;
      start <= 1'b0;
      while ((outstanding != 0 || busy) && waited < 4000) begin
         @(negedge clock);
         waited++;
      end
      repeat (linger) @(negedge clock);
   endtask

   function automatic longint span(input int d);
      if (d == 0)
         return 1;
      if (d > (1 << DIM_BITS))
         return longint'(1) << DIM_BITS;
      return d;
   endfunction

   // Favor the faces of the grid: that is where neighbors drop out.
   function automatic longint coord_pick(input longint n);
      int r;
      r = $urandom_range(0, 9);
      if (r < 3)
         return 0;
      if (r < 6)
         return n - 1;
      return longint'($urandom) % n;
   endfunction

   function automatic longint pick_origin();
      longint nx, ny, nz, tot, o;
      int     r;
      nx  = span(dim_x_set);
      ny  = span(dim_y_set);
      nz  = span(dim_z_set);
      tot = nx * ny * nz;
      r   = $urandom_range(0, 99);
      if (r < 55)
         o = coord_pick(nx) + nx * (coord_pick(ny) + ny * coord_pick(nz));
      else if (r < 70)
         o = longint'($urandom) % tot;
      else if (r < 85 && tot < IDX_LIMIT)
         o = tot + longint'($urandom) % (IDX_LIMIT - tot);   // past the grid
      else if (r < 92)
         o = $urandom_range(0, 1) ? IDX_LIMIT - 1 : 0;
      else
         o = longint'($urandom) % IDX_LIMIT;
      return o;
   endfunction

   function automatic int pick_dim();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return $urandom_range(1, 6);
      if (r < 75) return $urandom_range(7, 40);
      if (r < 82) return 0;
      if (r < 90) return 1 << DIM_BITS;
      if (r < 95) return $urandom_range((1 << DIM_BITS) + 1, (1 << gsne_pkg::DIM_CFG_W) - 1);
      return $urandom_range(1, 1 << DIM_BITS);
   endfunction

   // Every slot is loaded before this is used, so any count is safe.
   function automatic int pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return $urandom_range(MAX_NEIGHBORS + 1, (1 << gsne_pkg::CNT_CFG_W) - 1);
      if (r < 20) return MAX_NEIGHBORS;
      if (r < 25) return 0;
      return $urandom_range(1, MAX_NEIGHBORS - 1);
   endfunction

   // Mostly short hops so a fair share of neighbors land inside small grids.
   function automatic logic [gsne_pkg::DELTA_W-1:0] pick_delta();
      if ($urandom_range(0, 9) < 7)
         return gsne_pkg::DELTA_W'($urandom_range(0, 4) - 2);
      return gsne_pkg::DELTA_W'($urandom);
   endfunction

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_op          = gsne_pkg::OP_LOAD;
      req_entry_index = '0;
      req_delta_x     = '0;
      req_delta_y     = '0;
      req_delta_z     = '0;
      req_origin      = '0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      drain_check     = 1'b0;
      idle_pct        = 0;
      dim_x_set       = 1;
      dim_y_set       = 1;
      dim_z_set       = 1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed part ---
      // Reset grid and zero count: nothing to walk, so a single none-inside
      // response must come back with only the low x and y flags set.
      enumerate(5);
      settle(8);

      // Small 4x3x2 grid; stencil with self, both delta extremes and
      // single-axis and multi-axis hops.
      program_grid(4, 3, 2);
      load_slot(0, 4'sd0, 4'sd0, 4'sd0);
      load_slot(1, -4'sd8, -4'sd8, -4'sd8);
      load_slot(2, 4'sd7, 4'sd7, 4'sd7);
      load_slot(3, 4'sd1, 4'sd0, 4'sd0);
      load_slot(4, -4'sd1, 4'sd0, 4'sd0);
      load_slot(5, 4'sd0, 4'sd1, -4'sd1);
      load_slot(6, 4'sd0, -4'sd1, 4'sd1);
      load_slot(7, -4'sd8, 4'sd7, -4'sd1);
      settle(8);
      program_reg(gsne_pkg::REG_NBR_COUNT, 8);
      enumerate(0);                 // low corner
      enumerate(23);                // high corner
      enumerate(17);                // interior x and y
      enumerate(24);                // one past the grid
      enumerate(IDX_LIMIT - 1);     // far past the grid
      settle(8);

      // Zero extent reads as one; an oversize extent clamps to the widest.
      program_grid(0, 1, (1 << gsne_pkg::DIM_CFG_W) - 1);
      enumerate(0);
      enumerate((1 << DIM_BITS) - 1);
      enumerate(IDX_LIMIT - 1);
      settle(8);

      // Widest legal grid: the last vertex raises every high flag.
      program_grid(1 << DIM_BITS, 1 << DIM_BITS, 1 << DIM_BITS);
      enumerate(IDX_LIMIT - 1);
      enumerate(0);
      enumerate((1 << 29) + 7 * (1 << DIM_BITS) + 1023);
      settle(8);
      program_reg(gsne_pkg::REG_NBR_COUNT, 0);
      enumerate(100);
      settle(8);

      // --- random part ---
      // Fill the whole table first so later counts never reach a blank slot.
      for (int s = 0; s < MAX_NEIGHBORS; s++)
         load_slot(s, pick_delta(), pick_delta(), pick_delta());

      for (int ph = 0; ph < PHASES; ph++) begin
         settle(8);
         idle_pct = phase_idle[ph];
         program_grid(pick_dim(), pick_dim(), pick_dim());
         program_reg(gsne_pkg::REG_NBR_COUNT, pick_count());
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Occasionally drain completely mid-phase.
            if ($urandom_range(0, 99) < 3)
               settle(8);
            if ($urandom_range(0, 99) < 12)
               load_slot($urandom_range(0, MAX_NEIGHBORS - 1), pick_delta(), pick_delta(),
                         pick_delta());
            else
               enumerate(pick_origin());
         end
      end

      // Drain, then flag anything still pending.
      settle(100);
      drain_check <= 1'b1;
      @(negedge clock);
      drain_check <= 1'b0;
      @(negedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
